// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the ordered list store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define OLST_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ordered list store: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list store: sequence check violated");

`else

`define OLST_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/olst_pkg.sv =====
// Package with types, sizes and codes of the ordered list store.
`timescale 1ns / 1ps

package olst_pkg;

    // List capacity and derived widths.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int LEN_W = 5;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request modes.
    localparam logic [2:0] MODE_INS_HEAD = 3'd0;
    localparam logic [2:0] MODE_INS_TAIL = 3'd1;
    localparam logic [2:0] MODE_INS_POS  = 3'd2;
    localparam logic [2:0] MODE_FIND     = 3'd3;
    localparam logic [2:0] MODE_POS_TEST = 3'd4;
    localparam logic [2:0] MODE_DEL_VAL  = 3'd5;
    localparam logic [2:0] MODE_DEL_POS  = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Request and result payloads.
    typedef struct packed {
        logic [2:0]        mode;
        logic signed [31:0] value;
        logic [POS_W-1:0]  position;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [1:0]        status;
        logic [LEN_W-1:0]  length;
    } t_rsp;

    // Broadcast control from the list controller to every cell.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] at;
    } t_cell_ctl;

endpackage

// ===== rtl/core/ordered_list_store.sv =====
// The result is registered at its request transfer.
// Throughput: one request per cycle while results are taken; the row of cells
// compares, picks and shifts all entries in the cycle of the transfer.
// The result register frees up when its transfer completes or in the same cycle.
// Reset clears the entry count and the result valid flag; entry contents are
// left undefined and are only read below the count.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ordered_list_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  olst_pkg::t_req   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output olst_pkg::t_rsp   o_out_data
);
    import olst_pkg::*;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_rsp               r_out_data;
    t_rsp               n_rsp;
    logic               w_acc;
    t_cell_ctl          w_ctl;
    logic               w_ins;
    logic               w_del;
    logic [IDX_W-1:0]   w_at;
    logic [DEPTH-1:0]   w_hit_raw;
    logic [DEPTH-1:0]   w_hit;
    logic               w_any_hit;
    logic [IDX_W-1:0]   w_first;
    logic signed [31:0] w_cell_q [DEPTH];
    logic               w_full;
    logic               w_empty;
    logic [CMP_W-1:0]   w_pos_x;
    logic [CMP_W-1:0]   w_cnt_x;

    // Handshake: a new request transfers when the result register is free.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_acc      = i_in_valid & ~o_in_stall;

    // Row of cells, each shifting with its neighbors.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = i_in_data.value;
        end else begin : g_mid_l
            assign w_left = w_cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_cell_q[g];
        end else begin : g_mid_r
            assign w_right = w_cell_q[g+1];
        end
        olst_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_value (i_in_data.value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_q[g]),
            .o_hit   (w_hit_raw[g])
        );
        assign w_hit[g] = w_hit_raw[g] & (CNT_W'(g) < r_count);
    end

    // Priority pick of the first matching valid entry.
    always_comb begin
        w_first = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_first = IDX_W'(i);
            end
        end
    end
    assign w_any_hit = |w_hit;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_pos_x = CMP_W'(i_in_data.position);
    assign w_cnt_x = CMP_W'(r_count);

    // Request decode: pick the operation, its index and the result.
    always_comb begin
        w_ins        = 1'b0;
        w_del        = 1'b0;
        w_at         = '0;
        n_rsp.found  = 1'b0;
        n_rsp.status = ST_OK;
        case (i_in_data.mode)
            MODE_INS_HEAD: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            MODE_INS_TAIL: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_at  = IDX_W'(r_count);
                end
            end
            MODE_INS_POS: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    n_rsp.status = ST_MISS;
                end else begin
                    w_ins = 1'b1;
                    w_at  = IDX_W'(i_in_data.position);
                end
            end
            MODE_FIND: begin
                n_rsp.found  = w_any_hit;
                n_rsp.status = w_any_hit ? ST_OK : ST_MISS;
            end
            MODE_POS_TEST: begin
                if (w_pos_x < w_cnt_x) begin
                    n_rsp.found = 1'b1;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            MODE_DEL_VAL: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else if (w_any_hit) begin
                    w_del       = 1'b1;
                    w_at        = w_first;
                    n_rsp.found = 1'b1;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            MODE_DEL_POS: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    n_rsp.status = ST_MISS;
                end else begin
                    w_del       = 1'b1;
                    w_at        = IDX_W'(i_in_data.position);
                    n_rsp.found = 1'b1;
                end
            end
            default: begin
                n_rsp.status = ST_MISS;
            end
        endcase

        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_del) begin
            n_count = r_count - CNT_W'(1);
        end
        n_rsp.length = LEN_W'(n_count);
    end

    // Cells only move on a request transfer.
    assign w_ctl.ins = w_acc & w_ins;
    assign w_ctl.del = w_acc & w_del;
    assign w_ctl.at  = w_at;

    // Count and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_data <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The count never exceeds the capacity.
    `OLST_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    // A full status only comes from a full list.
    `OLST_ASSERT_ALWAYS(a_full_status, i_clk, i_rst_n, !(w_acc && n_rsp.status == ST_FULL) || w_full)
    // A found result always carries an ok status.
    `OLST_ASSERT_ALWAYS(a_found_ok, i_clk, i_rst_n, !n_rsp.found || n_rsp.status == ST_OK)
    // Without a transfer the count holds.
    `OLST_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !w_acc, r_count == $past(r_count))

endmodule

// ===== rtl/core/olst_cell.sv =====
// One storage cell of the list: holds an entry, compares it, and shifts with neighbors.
`timescale 1ns / 1ps

module olst_cell (
    input  logic                     i_clk,
    input  logic [olst_pkg::IDX_W-1:0] i_idx,
    input  olst_pkg::t_cell_ctl      i_ctl,
    input  logic signed [31:0]       i_value,
    input  logic signed [31:0]       i_left,
    input  logic signed [31:0]       i_right,
    output logic signed [31:0]       o_data,
    output logic                     o_hit
);
    import olst_pkg::*;

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    // Insert opens a gap at the target index; delete closes it from the right.
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_idx > i_ctl.at) begin
                n_data = i_left;
            end else if (i_idx == i_ctl.at) begin
                n_data = i_value;
            end
        end else if (i_ctl.del) begin
            if (i_idx >= i_ctl.at) begin
                n_data = i_right;
            end
        end
    end

    // Entry storage has no reset; entries beyond the count are never used.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = (r_data == i_value);

endmodule

// ===== test/ordered_list_store_check.sv =====
// Channel monitor for the ordered list store: predicts each result and compares it.
`timescale 1ns / 1ps

module ordered_list_store_check (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  olst_pkg::t_req   i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  olst_pkg::t_rsp   i_out_data,
    output int               o_fail_count,
    output int               o_pending
);

    import olst_pkg::*;

    // Shadow copy of the list: only slots below held_len are meaningful.
    logic signed [31:0] held_vals [DEPTH];
    int                 held_len = 0;
    t_rsp               expected_q [$];
    int                 mismatch_total = 0;

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   at;
        at = -1;
        rsp = '0;
        rsp.status = ST_OK;
        case (req.mode)
            MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS: begin
                // A full list rejects before the position is looked at.
                if (held_len >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (req.mode == MODE_INS_POS && req.position > held_len) begin
                    rsp.status = ST_MISS;
                end else begin
                    if (req.mode == MODE_INS_HEAD)
                        at = 0;
                    else if (req.mode == MODE_INS_TAIL)
                        at = held_len;
                    else
                        at = int'(req.position);
                    for (int i = held_len; i > at; i--)
                        held_vals[i] = held_vals[i - 1];
                    held_vals[at] = req.value;
                    held_len++;
                end
            end
            MODE_FIND: begin
                rsp.status = ST_MISS;
                for (int i = 0; i < held_len && at < 0; i++)
                    if (held_vals[i] == req.value)
                        at = i;
                if (at >= 0) begin
                    rsp.found = 1'b1;
                    rsp.status = ST_OK;
                end
            end
            MODE_POS_TEST: begin
                if (req.position < held_len)
                    rsp.found = 1'b1;
                else
                    rsp.status = ST_MISS;
            end
            MODE_DEL_VAL: begin
                if (held_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.status = ST_MISS;
                    for (int i = 0; i < held_len && at < 0; i++)
                        if (held_vals[i] == req.value)
                            at = i;
                end
            end
            MODE_DEL_POS: begin
                if (held_len == 0)
                    rsp.status = ST_EMPTY;
                else if (req.position >= held_len)
                    rsp.status = ST_MISS;
                else
                    at = int'(req.position);
            end
            default: begin
                rsp.status = ST_MISS;
            end
        endcase

        // Both delete modes close the gap at the chosen slot.
        if ((req.mode == MODE_DEL_VAL || req.mode == MODE_DEL_POS) && at >= 0) begin
            for (int i = at; i + 1 < held_len; i++)
                held_vals[i] = held_vals[i + 1];
            held_len--;
            rsp.found = 1'b1;
            rsp.status = ST_OK;
        end
        rsp.length = LEN_W'(held_len);
        return rsp;
    endfunction

    // Results are checked before the same edge's request is predicted, since
    // a result always belongs to an earlier request.
    always @(posedge i_clk) begin : watch_channels
        t_rsp want;
        if (!i_rst_n) begin
            held_len = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    mismatch_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_data.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_out_data.found);
                        mismatch_total++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               i_out_data.status);
                        mismatch_total++;
                    end
                    if (i_out_data.length !== want.length) begin
                        $error("length: expected %0d, actual %0d", want.length,
                               i_out_data.length);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(apply_request(i_in_data));
        end
        o_pending <= expected_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ===== test/ordered_list_store_test.sv =====
// Testbench top for the ordered list store: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ordered_list_store_test;

    import olst_pkg::*;

    // The mode field has one code that names no operation.
    localparam logic [2:0] MODE_SPARE = 3'd7;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int HOLD_LEN = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp_data;
    int   fail_total;
    int   pending_total;

    // Idle rates in percent and the count of long receiver hold-offs asked for.
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;

    ordered_list_store u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data)
    );

    ordered_list_store_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_in_data    (req_data),
        .i_out_valid  (rsp_valid),
        .i_out_stall  (rsp_stall),
        .i_out_data   (rsp_data),
        .o_fail_count (fail_total),
        .o_pending    (pending_total)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("ordered_list_store_test: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                rsp_stall <= 1'b1;
                hold_left--;
            end else begin
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic t_req build_request(input logic [2:0] mode,
                                           input logic signed [31:0] value,
                                           input logic [POS_W-1:0] position);
        t_req req;
        req.mode = mode;
        req.value = value;
        req.position = position;
        return req;
    endfunction

    // Values come mostly from a small pool so that finds and deletes hit.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -32'sd1;
            3, 4, 5, 6: return 32'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    // Mode mix leans toward inserts while filling and toward deletes while draining.
    function automatic logic [2:0] pick_mode(input bit filling);
        int roll;
        roll = $urandom_range(99);
        if (filling) begin
            if (roll < 25) return MODE_INS_HEAD;
            if (roll < 50) return MODE_INS_TAIL;
            if (roll < 70) return MODE_INS_POS;
            if (roll < 78) return MODE_FIND;
            if (roll < 84) return MODE_POS_TEST;
            if (roll < 92) return MODE_DEL_VAL;
            if (roll < 99) return MODE_DEL_POS;
        end else begin
            if (roll < 8) return MODE_INS_HEAD;
            if (roll < 16) return MODE_INS_TAIL;
            if (roll < 24) return MODE_INS_POS;
            if (roll < 34) return MODE_FIND;
            if (roll < 42) return MODE_POS_TEST;
            if (roll < 70) return MODE_DEL_VAL;
            if (roll < 98) return MODE_DEL_POS;
        end
        return MODE_SPARE;
    endfunction

    // Offers one request after an optional random gap and holds it until transfer.
    task automatic send_request(input t_req req);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= req;
        while (!taken) begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_total != 0);
        @(posedge clk);
    endtask

    initial begin : stimulus
        bit filling;
        logic [POS_W-1:0] position;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list cases, edge values, every mode, appends by position.
        send_request(build_request(MODE_DEL_POS, 32'sd0, 5'd0));
        send_request(build_request(MODE_DEL_VAL, 32'sd0, 5'd0));
        send_request(build_request(MODE_FIND, 32'sd0, 5'd0));
        send_request(build_request(MODE_POS_TEST, 32'sd0, 5'd0));
        send_request(build_request(MODE_INS_POS, 32'sd9, 5'd1));
        send_request(build_request(MODE_INS_POS, 32'sh7FFF_FFFF, 5'd0));
        send_request(build_request(MODE_INS_HEAD, 32'sh8000_0000, 5'd31));
        send_request(build_request(MODE_INS_TAIL, -32'sd1, 5'd0));
        send_request(build_request(MODE_INS_POS, 32'sd0, 5'd3));
        send_request(build_request(MODE_INS_POS, 32'sd0, 5'd1));
        send_request(build_request(MODE_FIND, -32'sd1, 5'd0));
        send_request(build_request(MODE_FIND, 32'sd12345, 5'd0));
        send_request(build_request(MODE_POS_TEST, 32'sd0, 5'd4));
        send_request(build_request(MODE_POS_TEST, 32'sd0, 5'd5));
        send_request(build_request(MODE_POS_TEST, 32'sd0, 5'd31));
        send_request(build_request(MODE_DEL_VAL, 32'sd0, 5'd0));
        send_request(build_request(MODE_DEL_VAL, 32'sd999, 5'd0));
        send_request(build_request(MODE_DEL_POS, 32'sd0, 5'd4));
        send_request(build_request(MODE_DEL_POS, 32'sd0, 5'd3));
        send_request(build_request(MODE_DEL_POS, 32'sd0, 5'd0));
        send_request(build_request(MODE_SPARE, 32'sh5A5A_A5A5, 5'd31));
        send_request(build_request(MODE_INS_TAIL, 32'sd31, 5'd31));
        drain_results();

        // Random phases: no idling, sender gaps, receiver stalls, light both.
        for (int phase = 0; phase < 4; phase++) begin
            send_gap_pct = (phase == 1) ? 82 : (phase == 3) ? 7 : 0;
            recv_stall_pct = (phase == 2) ? 82 : (phase == 3) ? 7 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Alternate fill and drain runs so the list hits both full and empty.
                filling = ((n / 30) % 2) == 0;
                if ($urandom_range(99) < 85)
                    position = POS_W'($urandom_range(17));
                else
                    position = POS_W'($urandom_range(31));
                // Long receiver hold-off while the sender keeps offering.
                if (phase == 0 && n == 60)
                    hold_requests++;
                send_request(build_request(pick_mode(filling), pick_value(), position));
            end
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (fail_total == 0)
            $display("ordered_list_store_test: PASS");
        else
            $display("ordered_list_store_test: FAIL");
        $finish;
    end

endmodule
